FILE: rtl/sphere_triangle_subdivider_core_defines.svh
// Assertion macros shared by the checker of the sphere subdivider core.
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_CORE_DEFINES_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SPHSUB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SPHSUB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sphsub_pkg.sv
// Shared types and constants of the sphere subdivider core.
`timescale 1ns / 1ps
package sphsub_pkg;

  // Edge codes: which pair of corners is summed.
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  // Division kinds.
  localparam logic DIV_NORMAL = 1'b0;
  localparam logic DIV_POS    = 1'b1;

  // Output record kinds.
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_BASE    = 2'd1;
  localparam logic [1:0] REG_REVERSE = 2'd2;

  // Last triangle of a group of four.
  localparam logic [1:0] TRI_LAST = 2'd3;

  localparam int unsigned RADIUS_BITS = 15;
  localparam int unsigned RADIUS_RST  = 16384;
  localparam int unsigned BASE_RST    = 12;
  localparam int unsigned NORMAL_ONE  = 16384;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       edge_sum;
    logic [1:0] edge_sel;
    logic       sq_acc;
    logic [1:0] axis;
    logic       root_init;
    logic       root_step;
    logic       mul_pos;
    logic       div_load;
    logic       div_kind;
    logic       div_step;
    logic       div_store;
    logic       out_vertex;
    logic       out_tri;
    logic [1:0] tri_sel;
  } cmd_t;

endpackage

FILE: rtl/sphere_triangle_subdivider_core.sv
// Top level of the sphere subdivider: configuration registers and stream ports.
// Each new vertex takes one digit-by-digit square root and six restoring divisions,
// one for the normal and one for the position on each axis.
// Each triangle yields seven output beats, three vertices and then four triangles.
// One triangle is processed at a time; the input is ready only while the core is idle.
// Reset is asynchronous and active low; it clears control state and loads register defaults.
`timescale 1ns / 1ps
module sphere_triangle_subdivider_core #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned INDEX_BITS = 20,
  localparam int unsigned IN_W  = ((3 * INDEX_BITS + 9 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((4 * INDEX_BITS + 6 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input beat: index_a, index_b, index_c, ax, ay, az, bx, by, bz, cx, cy, cz
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_W-1:0]                s_axis_tdata,
  // Output beat: vertex_index, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
  // corner_first, corner_second, corner_third
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_W-1:0]               m_axis_tdata,
  // Output kind: 0 vertex, 1 triangle
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sphsub_pkg::APB_AW-1:0]  paddr,
  input  logic [sphsub_pkg::APB_DW-1:0]  pwdata,
  output logic [sphsub_pkg::APB_DW-1:0]  prdata,
  output logic                           pready
);
  import sphsub_pkg::*;

  logic [RADIUS_BITS-1:0] radius_q;
  logic [INDEX_BITS-1:0]  base_q;
  logic                   rev_q;
  logic                   wr_en;
  logic [1:0]             reg_idx;
  logic                   base_wr;
  cmd_t                   cmd;

  // Register write decode.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign base_wr = wr_en && (reg_idx == REG_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_BITS'(RADIUS_RST);
      base_q   <= INDEX_BITS'(BASE_RST);
      rev_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RADIUS:  radius_q <= pwdata[RADIUS_BITS-1:0];
        REG_BASE:    base_q   <= pwdata[INDEX_BITS-1:0];
        REG_REVERSE: rev_q    <= pwdata[0];
        default:     ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    unique case (reg_idx)
      REG_RADIUS:  prdata = APB_DW'(radius_q);
      REG_BASE:    prdata = APB_DW'(base_q);
      REG_REVERSE: prdata = APB_DW'(rev_q);
      default:     prdata = '0;
    endcase
  end

  sphsub_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sphsub_dp #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata),
    .radius_i   (radius_q),
    .reverse_i  (rev_q),
    .base_wr_i  (base_wr),
    .base_val_i (pwdata[INDEX_BITS-1:0]),
    .out_data_o (m_axis_tdata),
    .out_kind_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

endmodule

FILE: rtl/sphsub_ctrl.sv
// Sequencing state machine of the sphere subdivider core.
`timescale 1ns / 1ps
module sphsub_ctrl #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sphsub_pkg::cmd_t  cmd_o
);
  import sphsub_pkg::*;

  localparam int unsigned ROOT_ITERS = COORD_BITS + 16;
  localparam int unsigned DIV_ITERS  = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int unsigned CNTW       = $clog2(ROOT_ITERS + 1);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_SUM   = 14'b00000000000010,
    ST_SQ    = 14'b00000000000100,
    ST_RINIT = 14'b00000000001000,
    ST_ROOT  = 14'b00000000010000,
    ST_NPREP = 14'b00000000100000,
    ST_DIV   = 14'b00000001000000,
    ST_STORE = 14'b00000010000000,
    ST_MUL   = 14'b00000100000000,
    ST_PPREP = 14'b00001000000000,
    ST_VLOAD = 14'b00010000000000,
    ST_VWAIT = 14'b00100000000000,
    ST_TLOAD = 14'b01000000000000,
    ST_TWAIT = 14'b10000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [1:0]      edge_q, edge_d;
  logic [1:0]      axis_q, axis_d;
  logic            kind_q, kind_d;
  logic [1:0]      tri_q, tri_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    edge_d      = edge_q;
    axis_d      = axis_q;
    kind_d      = kind_q;
    tri_d       = tri_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o          = '0;
    cmd_o.edge_sel = edge_q;
    cmd_o.axis     = axis_q;
    cmd_o.div_kind = kind_q;
    cmd_o.tri_sel  = tri_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          edge_d        = EDGE_AB;
          state_d       = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.edge_sum = 1'b1;
        axis_d         = 2'd0;
        state_d        = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq_acc = 1'b1;
        if (axis_q == 2'd2) begin
          axis_d  = 2'd0;
          state_d = ST_RINIT;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_RINIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNTW'(ROOT_ITERS - 1)) begin
          kind_d  = DIV_NORMAL;
          state_d = ST_NPREP;
        end
      end
      ST_NPREP, ST_PPREP: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNTW'(DIV_ITERS - 1)) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.div_store = 1'b1;
        if (kind_q == DIV_NORMAL) begin
          kind_d  = DIV_POS;
          state_d = ST_MUL;
        end else if (axis_q == 2'd2) begin
          state_d = ST_VLOAD;
        end else begin
          axis_d  = axis_q + 2'd1;
          kind_d  = DIV_NORMAL;
          state_d = ST_NPREP;
        end
      end
      ST_MUL: begin
        cmd_o.mul_pos = 1'b1;
        state_d       = ST_PPREP;
      end
      ST_VLOAD: begin
        cmd_o.out_vertex = 1'b1;
        state_d          = ST_VWAIT;
      end
      ST_VWAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          unique case (edge_q)
            EDGE_AB: begin
              edge_d  = EDGE_BC;
              state_d = ST_SUM;
            end
            EDGE_BC: begin
              edge_d  = EDGE_CA;
              state_d = ST_SUM;
            end
            default: begin
              tri_d   = 2'd0;
              state_d = ST_TLOAD;
            end
          endcase
        end
      end
      ST_TLOAD: begin
        cmd_o.out_tri = 1'b1;
        state_d       = ST_TWAIT;
      end
      ST_TWAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (tri_q == TRI_LAST) begin
            state_d = ST_IDLE;
          end else begin
            tri_d   = tri_q + 2'd1;
            state_d = ST_TLOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      edge_q  <= EDGE_AB;
      axis_q  <= 2'd0;
      kind_q  <= DIV_NORMAL;
      tri_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      edge_q  <= edge_d;
      axis_q  <= axis_d;
      kind_q  <= kind_d;
      tri_q   <= tri_d;
    end
  end

endmodule

FILE: rtl/sphsub_dp.sv
// Arithmetic datapath: edge sums, square root, a shared divider and output record.
`timescale 1ns / 1ps
module sphsub_dp #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned INDEX_BITS = 20,
  localparam int unsigned IN_W  = ((3 * INDEX_BITS + 9 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((4 * INDEX_BITS + 6 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sphsub_pkg::cmd_t                    cmd_i,
  input  logic [IN_W-1:0]                     in_data_i,
  input  logic [sphsub_pkg::RADIUS_BITS-1:0]  radius_i,
  input  logic                                reverse_i,
  input  logic                                base_wr_i,
  input  logic [INDEX_BITS-1:0]               base_val_i,
  output logic [OUT_W-1:0]                    out_data_o,
  output logic                                out_kind_o,
  output logic                                out_last_o
);
  import sphsub_pkg::*;

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned IB  = INDEX_BITS;
  localparam int unsigned MW  = C + 1;
  localparam int unsigned MBW = (MW > RADIUS_BITS) ? MW : RADIUS_BITS;
  localparam int unsigned PW  = MW + MBW;
  localparam int unsigned QW  = 2 * MW + 2;
  localparam int unsigned VW  = QW + 28;
  localparam int unsigned LW  = VW / 2;
  localparam int unsigned QTW = (C > 16) ? C : 16;
  localparam int unsigned NNW = MW + 28;
  localparam int unsigned PNW = PW + 14;
  localparam int unsigned SW  = LW + QTW;
  localparam int unsigned DW0 = (NNW > PNW) ? ((NNW > SW) ? NNW : SW) : ((PNW > SW) ? PNW : SW);
  localparam int unsigned DW  = DW0 + 1;

  localparam logic [QTW-1:0] POS_MAX = {{(QTW - C + 1){1'b0}}, {(C - 1){1'b1}}};
  localparam logic [QTW-1:0] NRM_MAX = QTW'(NORMAL_ONE);

  // Captured input beat.
  logic [IB-1:0]        ind_q [3];
  logic signed [C-1:0]  crd_q [3][3];
  // Edge sum as sign and magnitude.
  logic                 sgn_q [3];
  logic [MW-1:0]        mag_q [3];
  // Sum of squares, root and divider state.
  logic [QW-1:0]        acc_q;
  logic [VW-1:0]        rv_q, res_q, bit_q;
  logic [LW-1:0]        l_q;
  logic [PW-1:0]        prod_q;
  logic [DW-1:0]        rem_q, dsr_q;
  logic [QTW-1:0]       quo_q;
  logic                 sat_q;
  // Finished vertex fields and indexes.
  logic [C-1:0]         pos_q [3];
  logic [C-1:0]         nrm_q [3];
  logic [IB-1:0]        vidx_q [3];
  logic [IB-1:0]        nvi_q;
  // Output record.
  logic [OUT_W-1:0]     out_q;
  logic                 kind_q, last_q;

  logic signed [C-1:0]  p_sel [3];
  logic signed [C-1:0]  r_sel [3];
  logic signed [C+1:0]  sum_w [3];
  logic [MW-1:0]        mag_sel;
  logic [MBW-1:0]       mul_b;
  logic [PW-1:0]        prod_w;
  logic [VW-1:0]        trial_w;
  logic [DW-1:0]        num_w, num_r_w;
  logic [QTW-1:0]       cap_w, mag_out_w;
  logic [C-1:0]         val_w;
  logic [IB-1:0]        tf_w, tg_w, th_w;

  // Corner pair of the current edge.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (cmd_i.edge_sel)
        EDGE_BC: begin
          p_sel[i] = crd_q[1][i];
          r_sel[i] = crd_q[2][i];
        end
        EDGE_CA: begin
          p_sel[i] = crd_q[2][i];
          r_sel[i] = crd_q[0][i];
        end
        default: begin
          p_sel[i] = crd_q[0][i];
          r_sel[i] = crd_q[1][i];
        end
      endcase
      sum_w[i] = (C + 2)'(p_sel[i]) + (C + 2)'(r_sel[i]);
    end
  end

  // Shared multiplier: squares of the magnitudes, then magnitude times radius.
  assign mag_sel = mag_q[cmd_i.axis];
  assign mul_b   = cmd_i.mul_pos ? MBW'(radius_i) : MBW'(mag_sel);
  assign prod_w  = PW'(mag_sel) * PW'(mul_b);

  // One step of the digit-by-digit square root.
  assign trial_w = res_q + bit_q;

  // Rounded numerator of the next division.
  always_comb begin
    if (cmd_i.div_kind == DIV_POS) begin
      num_w = DW'({prod_q, 14'b0});
    end else begin
      num_w = DW'({mag_sel, 28'b0});
    end
    num_r_w = num_w + DW'(l_q[LW-1:1]);
  end

  // Saturation and sign of the finished quotient.
  always_comb begin
    cap_w = (cmd_i.div_kind == DIV_POS) ? POS_MAX : NRM_MAX;
    if (l_q == '0) begin
      mag_out_w = '0;
    end else if (sat_q || (quo_q > cap_w)) begin
      mag_out_w = cap_w;
    end else begin
      mag_out_w = quo_q;
    end
    val_w = sgn_q[cmd_i.axis] ? C'(QTW'(0) - mag_out_w) : C'(mag_out_w);
  end

  // Corners of the selected output triangle.
  always_comb begin
    unique case (cmd_i.tri_sel)
      2'd0: begin
        tf_w = ind_q[0];
        tg_w = vidx_q[0];
        th_w = vidx_q[2];
      end
      2'd1: begin
        tf_w = ind_q[1];
        tg_w = vidx_q[1];
        th_w = vidx_q[0];
      end
      2'd2: begin
        tf_w = ind_q[2];
        tg_w = vidx_q[2];
        th_w = vidx_q[1];
      end
      default: begin
        tf_w = vidx_q[0];
        tg_w = vidx_q[1];
        th_w = vidx_q[2];
      end
    endcase
  end

  // Running vertex index, saturating at the top.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvi_q <= IB'(BASE_RST);
    end else if (base_wr_i) begin
      nvi_q <= base_val_i;
    end else if (cmd_i.edge_sum && (nvi_q != '1)) begin
      nvi_q <= nvi_q + 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      for (int k = 0; k < 3; k++) begin
        ind_q[k] <= in_data_i[k*IB +: IB];
        for (int i = 0; i < 3; i++) begin
          crd_q[k][i] <= in_data_i[3*IB + (3*k + i)*C +: C];
        end
      end
    end
    if (cmd_i.edge_sum) begin
      for (int i = 0; i < 3; i++) begin
        sgn_q[i] <= sum_w[i][C+1];
        mag_q[i] <= sum_w[i][C+1] ? MW'(-sum_w[i]) : MW'(sum_w[i]);
      end
      vidx_q[cmd_i.edge_sel] <= nvi_q;
      acc_q <= '0;
    end
    if (cmd_i.sq_acc) begin
      acc_q <= acc_q + QW'(prod_w[2*MW-1:0]);
    end
    if (cmd_i.root_init) begin
      rv_q  <= {acc_q, 28'b0};
      res_q <= '0;
      bit_q <= VW'(1) << (VW - 2);
    end
    if (cmd_i.root_step) begin
      if (rv_q >= trial_w) begin
        rv_q  <= rv_q - trial_w;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_load) begin
      l_q   <= l_q;
      rem_q <= num_r_w;
      dsr_q <= DW'(l_q) << (QTW - 1);
      sat_q <= num_r_w >= (DW'(l_q) << QTW);
      quo_q <= '0;
    end
    if (cmd_i.root_step) begin
      l_q <= LW'((rv_q >= trial_w) ? ((res_q >> 1) + bit_q) : (res_q >> 1));
    end
    if (cmd_i.mul_pos) begin
      prod_q <= prod_w;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dsr_q) begin
        rem_q <= rem_q - dsr_q;
        quo_q <= {quo_q[QTW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QTW-2:0], 1'b0};
      end
      dsr_q <= dsr_q >> 1;
    end
    if (cmd_i.div_store) begin
      if (cmd_i.div_kind == DIV_POS) begin
        pos_q[cmd_i.axis] <= val_w;
      end else begin
        nrm_q[cmd_i.axis] <= val_w;
      end
    end
    if (cmd_i.out_vertex) begin
      out_q  <= OUT_W'({{(3*IB){1'b0}}, nrm_q[2], nrm_q[1], nrm_q[0],
                        pos_q[2], pos_q[1], pos_q[0], vidx_q[cmd_i.edge_sel]});
      kind_q <= KIND_VERTEX;
      last_q <= 1'b0;
    end
    if (cmd_i.out_tri) begin
      if (reverse_i) begin
        out_q <= OUT_W'({tf_w, tg_w, th_w, {(6*C + IB){1'b0}}});
      end else begin
        out_q <= OUT_W'({th_w, tg_w, tf_w, {(6*C + IB){1'b0}}});
      end
      kind_q <= KIND_TRI;
      last_q <= (cmd_i.tri_sel == TRI_LAST);
    end
  end

  assign out_data_o = out_q;
  assign out_kind_o = kind_q;
  assign out_last_o = last_q;

endmodule

FILE: rtl/sphsub_checker.sv
// Port-level checker of the sphere subdivider core and its bind.
`timescale 1ns / 1ps
`include "sphere_triangle_subdivider_core_defines.svh"
module sphsub_checker #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned INDEX_BITS = 20,
  localparam int unsigned IN_W  = ((3 * INDEX_BITS + 9 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((4 * INDEX_BITS + 6 * COORD_BITS + 7) / 8) * 8
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [IN_W-1:0]                s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [OUT_W-1:0]               m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [sphsub_pkg::APB_AW-1:0]  paddr,
  input logic [sphsub_pkg::APB_DW-1:0]  pwdata,
  input logic [sphsub_pkg::APB_DW-1:0]  prdata,
  input logic                           pready
);

  // A triangle is taken only when no result beat is pending.
  `SPHSUB_ASSERT(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input ready while output valid")

  // A new triangle needs arithmetic before any beat appears.
  `SPHSUB_ASSERT_NEXT(a_no_early_out, s_axis_tvalid && s_axis_tready, !m_axis_tvalid,
    "output beat right after input accept")

  // The closing beat of a group is a triangle record.
  `SPHSUB_ASSERT(a_last_is_tri, m_axis_tvalid && m_axis_tlast, m_axis_tuser,
    "last beat is not a triangle")

  // After the closing beat the core is ready again.
  `SPHSUB_ASSERT_NEXT(a_ready_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast,
    s_axis_tready, "not ready after last beat")

  // A stalled output beat holds.
  `SPHSUB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled output beat changed")

endmodule

bind sphere_triangle_subdivider_core sphsub_checker #(
  .COORD_BITS (COORD_BITS),
  .INDEX_BITS (INDEX_BITS)
) u_checker (.*);

FILE: bench/tb_top.sv
// Self-checking testbench for the sphere triangle subdivider core.
`timescale 1ns / 1ps
module tb_top;
  import sphsub_pkg::*;

  localparam int unsigned IN_W  = 208;
  localparam int unsigned OUT_W = 176;
  localparam logic [19:0] INDEX_TOP = 20'hFFFFF;

  // One expected output beat, fields as the core emits them.
  typedef struct {
    logic        kind;
    logic [19:0] vertex_index;
    logic [15:0] pos[3];
    logic [15:0] nrm[3];
    logic [19:0] corner[3];
    logic        last;
  } mesh_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  sphere_triangle_subdivider_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the configuration and the running vertex counter.
  logic [14:0] radius_q = 15'd16384;
  logic [19:0] next_index_q = 20'd12;
  logic        reverse_q = 1'b0;

  logic [IN_W-1:0] tri_pending[$];
  mesh_rec_t       mesh_expected[$];
  bit              failed = 1'b0;
  bit              no_gaps = 1'b0;

  // Appends one triangle to the send queue.
  function automatic void queue_triangle(logic [IN_W-1:0] d);
    tri_pending = {tri_pending, d};
  endfunction

  // Appends one beat to the expected queue.
  function automatic void add_expected(mesh_rec_t r);
    mesh_expected = {mesh_expected, r};
  endfunction

  // Mostly short gaps, a few long ones; none while no_gaps is set.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [19:0] take_index();
    logic [19:0] idx;
    idx = next_index_q;
    if (next_index_q < INDEX_TOP) next_index_q++;
    return idx;
  endfunction

  // Normalizes one edge sum into a new vertex record.
  function automatic mesh_rec_t midpoint_vertex(longint sum[3], logic [19:0] idx);
    mesh_rec_t r;
    longint unsigned mag[3], q, l, n, p;
    q = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (sum[i] < 0) ? -sum[i] : sum[i];
      q += mag[i] * mag[i];
    end
    l = isqrt(q << 28);
    r.kind = KIND_VERTEX;
    r.vertex_index = idx;
    r.last = 1'b0;
    for (int i = 0; i < 3; i++) begin
      n = 0;
      p = 0;
      if (l != 0) begin
        n = ((mag[i] << 28) + l / 2) / l;
        p = (((mag[i] * radius_q) << 14) + l / 2) / l;
      end
      if (n > NORMAL_ONE) n = NORMAL_ONE;
      if (p > 32767) p = 32767;
      r.nrm[i] = (sum[i] < 0) ? -n[15:0] : n[15:0];
      r.pos[i] = (sum[i] < 0) ? -p[15:0] : p[15:0];
      r.corner[i] = '0;
    end
    return r;
  endfunction

  function automatic mesh_rec_t child_triangle(logic [19:0] f, logic [19:0] g,
                                               logic [19:0] h);
    mesh_rec_t r;
    r.kind = KIND_TRI;
    r.vertex_index = '0;
    r.last = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = '0;
      r.nrm[i] = '0;
    end
    r.corner[0] = reverse_q ? h : f;
    r.corner[1] = g;
    r.corner[2] = reverse_q ? f : h;
    return r;
  endfunction

  // Expands one accepted triangle into its seven expected beats.
  task automatic predict_subdivision(logic [IN_W-1:0] d);
    logic [19:0] ia, ib, ic, iab, ibc, ica;
    longint a[3], b[3], c[3], s[3];
    mesh_rec_t t;
    ia = d[19:0];
    ib = d[39:20];
    ic = d[59:40];
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(d[60 + 16*i +: 16]);
      b[i] = $signed(d[108 + 16*i +: 16]);
      c[i] = $signed(d[156 + 16*i +: 16]);
    end
    iab = take_index();
    for (int i = 0; i < 3; i++) s[i] = a[i] + b[i];
    add_expected(midpoint_vertex(s, iab));
    ibc = take_index();
    for (int i = 0; i < 3; i++) s[i] = b[i] + c[i];
    add_expected(midpoint_vertex(s, ibc));
    ica = take_index();
    for (int i = 0; i < 3; i++) s[i] = c[i] + a[i];
    add_expected(midpoint_vertex(s, ica));
    add_expected(child_triangle(ia, iab, ica));
    add_expected(child_triangle(ib, ibc, iab));
    add_expected(child_triangle(ic, ica, ibc));
    t = child_triangle(iab, ibc, ica);
    t.last = 1'b1;
    add_expected(t);
  endtask

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Input driver: holds a beat until accepted, then moves on after a random gap.
  int unsigned in_gap = 0;
  bit in_taken = 1'b0;
  always @(posedge clk_i) in_taken <= s_axis_tvalid && s_axis_tready;

  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !in_taken)) begin
      if (in_gap > 0 || tri_pending.size() == 0) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata <= tri_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        in_gap <= draw_gap();
      end
    end
  end

  // Output stalls.
  int unsigned out_gap = 0;
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      out_gap <= draw_gap();
    end
  end

  // Monitor: predicts on accepted inputs and checks every output beat.
  always @(posedge clk_i) begin
    mesh_rec_t e;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_subdivision(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (mesh_expected.size() == 0) begin
          $error("unexpected output beat %0h", m_axis_tdata);
          failed = 1'b1;
        end else begin
          e = mesh_expected.pop_front();
          check_field("kind", e.kind, m_axis_tuser);
          check_field("last", e.last, m_axis_tlast);
          check_field("vertex_index", e.vertex_index, m_axis_tdata[19:0]);
          check_field("pos_x", e.pos[0], m_axis_tdata[35:20]);
          check_field("pos_y", e.pos[1], m_axis_tdata[51:36]);
          check_field("pos_z", e.pos[2], m_axis_tdata[67:52]);
          check_field("normal_x", e.nrm[0], m_axis_tdata[83:68]);
          check_field("normal_y", e.nrm[1], m_axis_tdata[99:84]);
          check_field("normal_z", e.nrm[2], m_axis_tdata[115:100]);
          check_field("corner_first", e.corner[0], m_axis_tdata[135:116]);
          check_field("corner_second", e.corner[1], m_axis_tdata[155:136]);
          check_field("corner_third", e.corner[2], m_axis_tdata[175:156]);
        end
      end
    end
  end

  function automatic logic [IN_W-1:0] pack_triangle(logic [19:0] ia, logic [19:0] ib,
                                                    logic [19:0] ic,
                                                    logic [8:0][15:0] crd);
    return {4'd0, crd, ic, ib, ia};
  endfunction

  function automatic logic [15:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
    if (r < 9) return 16'($urandom);
    return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
  endfunction

  // Random triangle; some have antipodal corners so an edge sum vanishes.
  function automatic logic [IN_W-1:0] rand_triangle();
    logic [8:0][15:0] crd;
    for (int i = 0; i < 9; i++) crd[i] = rand_coord();
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < 3; i++) crd[3 + i] = -crd[i];
    end
    return pack_triangle(20'($urandom), 20'($urandom), 20'($urandom), crd);
  endfunction

  // Register write over the configuration port, mirrored into the shadow copy.
  task automatic write_reg(logic [1:0] reg_sel, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (reg_sel)
      REG_RADIUS: radius_q = value[14:0];
      REG_BASE: next_index_q = value[19:0];
      REG_REVERSE: reverse_q = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until the core has delivered everything and sits idle.
  task automatic drain();
    while (tri_pending.size() != 0 || s_axis_tvalid || mesh_expected.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [14:0] rad, logic [19:0] base, logic rev,
                           int unsigned count, bit steady);
    write_reg(REG_RADIUS, 32'(rad));
    write_reg(REG_BASE, 32'(base));
    write_reg(REG_REVERSE, 32'(rev));
    no_gaps = steady;
    repeat (count) queue_triangle(rand_triangle());
    drain();
  endtask

  initial begin
    logic [8:0][15:0] crd;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed triangles under the reset configuration.
    for (int i = 0; i < 9; i++) crd[i] = 16'sd16384;
    queue_triangle(pack_triangle(20'd0, 20'd0, 20'd0, crd));
    for (int i = 0; i < 9; i++) crd[i] = -16'sd16384;
    queue_triangle(pack_triangle(INDEX_TOP, INDEX_TOP, INDEX_TOP, crd));
    for (int i = 0; i < 9; i++) crd[i] = (i % 2 == 0) ? 16'h7FFF : 16'h8000;
    queue_triangle(pack_triangle(20'h55555, 20'hAAAAA, 20'd1, crd));
    // Every edge sum zero: all three corners at the origin.
    crd = '0;
    queue_triangle(pack_triangle(20'd3, 20'd4, 20'd5, crd));
    // Antipodal a and b, unit axes elsewhere.
    crd = '0;
    crd[0] = 16'sd16384;
    crd[3] = -16'sd16384;
    crd[7] = 16'sd16384;
    queue_triangle(pack_triangle(20'd0, 20'd1, 20'd2, crd));
    // Tiny vectors, where rounding matters most.
    crd = '0;
    crd[0] = 16'sd1;
    crd[4] = -16'sd1;
    crd[8] = 16'sd1;
    queue_triangle(pack_triangle(20'd7, 20'd8, 20'd9, crd));
    repeat (6) queue_triangle(rand_triangle());
    drain();

    // Sender pauses until all results are back before each reconfiguration.
    run_phase(15'd1, 20'd0, 1'b1, 80, 1'b0);
    // Counter runs into saturation at the top index.
    run_phase(15'd16384, 20'hFFFF8, 1'b0, 60, 1'b1);
    run_phase(15'($urandom_range(1, 16384)), 20'($urandom), 1'($urandom), 110, 1'b0);
    run_phase(15'd7000, 20'd12, 1'b1, 110, 1'b0);
    run_phase(15'd16384, 20'd1000, 1'b0, 110, 1'b0);

    repeat (600) @(posedge clk_i);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
